// ===== rtl/all_sources_shortest_path_tree_unit_assert.svh =====
// Assertion macros for the shortest path tree unit.
// Used by the top level; depends on nothing.
`ifndef ALL_SOURCES_SHORTEST_PATH_TREE_UNIT_ASSERT_SVH
`define ALL_SOURCES_SHORTEST_PATH_TREE_UNIT_ASSERT_SVH

// condition must never hold in any cycle out of reset
`define ASPTU_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASPTU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/asptu_pkg.sv =====
// Shared types and constants for the shortest path tree unit.
// No dependencies.
package asptu_pkg;

   localparam int DEF_MAX_NODES = 32;
   localparam int DEF_MAX_EDGES = 64;
   localparam int DEF_COST_BITS = 16;

   localparam int NODE_W    = 5;
   localparam int COUNT_W   = 6;
   localparam int OUT_LIMIT = 32;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 6'd32;

   // command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_BUILD = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [NODE_W-1:0] edge_from;
      logic [NODE_W-1:0] edge_to;
      logic [15:0]       edge_cost;
      logic [NODE_W-1:0] start_node;
      logic [NODE_W-1:0] end_node;
   } req_word_type;

   typedef struct packed {
      logic [NODE_W-1:0] path_node;
      logic              found;
      logic              last;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PCLR,
      ST_INIT,
      ST_EREAD,
      ST_ECHK,
      ST_ERELAX,
      ST_STEPEND,
      ST_SREAD,
      ST_SCMP,
      ST_SRCEND,
      ST_QTEST,
      ST_QREAD,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/asptu_ram.sv =====
// Simple dual port synchronous RAM, one write and one registered read port.
// No dependencies.
module asptu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/all_sources_shortest_path_tree_unit.sv =====
// Build: clears all MAX_NODES^2 predecessor entries, then, per source in use,
//   alternates an edge scan over the edge RAM with a node selection pass.
// Query: a predecessor read per hop, then one word per node. Clear/add: on acceptance.
// One word in flight at a time; req_stall is high until the build or query is done.
// Synchronous active-high reset: edge count 0, node_count 32, no tree built.
// Top level; uses asptu_pkg, asptu_ram and the assertion macro header.
`include "all_sources_shortest_path_tree_unit_assert.svh"

module all_sources_shortest_path_tree_unit #(
   parameter int MAX_NODES = asptu_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = asptu_pkg::DEF_MAX_EDGES,
   parameter int COST_BITS = asptu_pkg::DEF_COST_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  asptu_pkg::req_word_type        req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output asptu_pkg::rsp_word_type        rsp_word,
   input  logic                           csr_we,
   input  logic [asptu_pkg::COUNT_W-1:0]  csr_wdata
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int NCW = NW + 1;
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int PD  = MAX_NODES * MAX_NODES;
   localparam int PAW = $clog2(PD);
   localparam int TW  = COST_BITS + 8;
   localparam int EW  = 2 * asptu_pkg::NODE_W + COST_BITS;
   localparam int PDW = NW + 1;
   localparam int NDW = asptu_pkg::NODE_W;

   localparam logic [COST_BITS-1:0] COST_INF  = {COST_BITS{1'b1}};
   localparam logic [TW-1:0]        TOTAL_INF = {TW{1'b1}};

   asptu_pkg::state_type state_ff, state_in;

   logic [asptu_pkg::COUNT_W-1:0] node_count_ff;
   logic [ECW-1:0]  edge_count_ff;
   logic [NCW-1:0]  n_ff;
   logic            built_ff;
   logic [PAW-1:0]  clr_ff;
   logic [NW-1:0]   src_ff, k_ff, cur_ff, best_ff;
   logic [NCW-1:0]  step_ff;
   logic [EAW-1:0]  e_ff;
   logic [TW-1:0]   cur_total_ff, best_cost_ff;
   logic            have_ff;
   logic [NDW-1:0]  oth_ff;
   logic [COST_BITS-1:0] ecost_ff;
   logic [MAX_NODES-1:0] visited_ff, seen_ff;

   logic [NDW-1:0]  qstart_ff;
   logic [NW-1:0]   qnode_ff;
   logic [asptu_pkg::COUNT_W-1:0] cnt_ff, len_ff;
   logic [NDW-1:0]  idx_ff;
   logic            found_ff;
   logic [NDW-1:0]  path_buf_ff [asptu_pkg::OUT_LIMIT];

   // memory ports
   logic            edge_we, edge_re;
   logic [EW-1:0]   edge_rd;
   logic            tot_we, tot_re;
   logic [NW-1:0]   tot_waddr, tot_raddr;
   logic [TW-1:0]   tot_wdata, tot_rd;
   logic            pred_we, pred_re;
   logic [PAW-1:0]  pred_waddr, pred_raddr;
   logic [PDW-1:0]  pred_wdata, pred_rd;

   logic req_acc, rsp_acc;
   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // edge word fields
   logic [NDW-1:0]       ea, eb, oth;
   logic [COST_BITS-1:0] ec;
   logic                 hit_a, hit_b, relevant;
   logic [NW-1:0]        oth_idx;
   assign ea    = edge_rd[EW-1 -: NDW];
   assign eb    = edge_rd[EW-NDW-1 -: NDW];
   assign ec    = edge_rd[COST_BITS-1:0];
   assign hit_a = (int'(ea) == int'(cur_ff));
   assign hit_b = (int'(eb) == int'(cur_ff));
   assign oth   = hit_a ? eb : ea;
   assign oth_idx = NW'(oth);
   assign relevant = (hit_a || hit_b) && (int'(oth) < int'(n_ff))
                     && !visited_ff[oth_idx] && !seen_ff[oth_idx];

   // relaxation sum, saturated
   logic [TW:0]   sum_raw;
   logic [TW-1:0] sum_sat;
   assign sum_raw = (TW+1)'(ecost_ff) + (TW+1)'(cur_total_ff);
   assign sum_sat = sum_raw[TW] ? TOTAL_INF : sum_raw[TW-1:0];

   // loop end flags
   logic k_last, e_last, step_last, src_last, clr_last, idx_last;
   assign k_last    = (NCW'(k_ff) + NCW'(1)) == n_ff;
   assign src_last  = (NCW'(src_ff) + NCW'(1)) == n_ff;
   assign step_last = (step_ff + NCW'(1)) == n_ff;
   assign e_last    = (ECW'(e_ff) + ECW'(1)) == edge_count_ff;
   assign clr_last  = clr_ff == PAW'(PD - 1);
   assign idx_last  = (asptu_pkg::COUNT_W'(idx_ff) + asptu_pkg::COUNT_W'(1)) == len_ff;

   // selection compare
   logic take;
   assign take = !visited_ff[k_ff] && (!have_ff || tot_rd < best_cost_ff);

   // query checks
   logic q_bad, q_home, q_limit;
   assign q_bad   = (int'(req_word.start_node) >= MAX_NODES)
                    || (int'(req_word.end_node) >= MAX_NODES) || !built_ff;
   assign q_home  = int'(qnode_ff) == int'(qstart_ff);
   assign q_limit = (int'(cnt_ff) >= asptu_pkg::OUT_LIMIT - 1) || (int'(cnt_ff) >= MAX_NODES);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         asptu_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (req_word.command)
                  asptu_pkg::CMD_BUILD: state_in = asptu_pkg::ST_PCLR;
                  asptu_pkg::CMD_QUERY: begin
                     if (req_word.start_node == req_word.end_node || q_bad) begin
                        state_in = asptu_pkg::ST_EMIT;
                     end else begin
                        state_in = asptu_pkg::ST_QTEST;
                     end
                  end
                  default: state_in = asptu_pkg::ST_IDLE;
               endcase
            end
         end
         asptu_pkg::ST_PCLR: begin
            if (clr_last) begin
               state_in = (n_ff == '0) ? asptu_pkg::ST_IDLE : asptu_pkg::ST_INIT;
            end
         end
         asptu_pkg::ST_INIT: begin
            if (k_last) begin
               state_in = (edge_count_ff == '0) ? asptu_pkg::ST_STEPEND : asptu_pkg::ST_EREAD;
            end
         end
         asptu_pkg::ST_EREAD: state_in = asptu_pkg::ST_ECHK;
         asptu_pkg::ST_ECHK: begin
            priority if (relevant && ec != COST_INF) state_in = asptu_pkg::ST_ERELAX;
            else if (e_last) state_in = asptu_pkg::ST_STEPEND;
            else state_in = asptu_pkg::ST_EREAD;
         end
         asptu_pkg::ST_ERELAX: begin
            state_in = e_last ? asptu_pkg::ST_STEPEND : asptu_pkg::ST_EREAD;
         end
         asptu_pkg::ST_STEPEND: begin
            state_in = step_last ? asptu_pkg::ST_SRCEND : asptu_pkg::ST_SREAD;
         end
         asptu_pkg::ST_SREAD: state_in = asptu_pkg::ST_SCMP;
         asptu_pkg::ST_SCMP: begin
            if (k_last) begin
               priority if (!(have_ff || take)) state_in = asptu_pkg::ST_SRCEND;
               else if (edge_count_ff == '0) state_in = asptu_pkg::ST_STEPEND;
               else state_in = asptu_pkg::ST_EREAD;
            end else begin
               state_in = asptu_pkg::ST_SREAD;
            end
         end
         asptu_pkg::ST_SRCEND: begin
            state_in = src_last ? asptu_pkg::ST_IDLE : asptu_pkg::ST_INIT;
         end
         asptu_pkg::ST_QTEST: begin
            state_in = (q_home || q_limit) ? asptu_pkg::ST_EMIT : asptu_pkg::ST_QREAD;
         end
         asptu_pkg::ST_QREAD: begin
            state_in = pred_rd[PDW-1] ? asptu_pkg::ST_QTEST : asptu_pkg::ST_EMIT;
         end
         asptu_pkg::ST_EMIT: begin
            if (rsp_acc && idx_last) state_in = asptu_pkg::ST_IDLE;
         end
         default: state_in = asptu_pkg::ST_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_stall  = state_ff != asptu_pkg::ST_IDLE;
      rsp_valid  = state_ff == asptu_pkg::ST_EMIT;
      edge_we    = req_acc && req_word.command == asptu_pkg::CMD_ADD
                   && int'(edge_count_ff) < MAX_EDGES;
      edge_re    = state_ff == asptu_pkg::ST_EREAD;
      tot_we     = 1'b0;
      tot_waddr  = k_ff;
      tot_wdata  = (k_ff == src_ff) ? '0 : TOTAL_INF;
      tot_re     = 1'b0;
      tot_raddr  = k_ff;
      pred_we    = 1'b0;
      pred_waddr = clr_ff;
      pred_wdata = '0;
      pred_re    = state_ff == asptu_pkg::ST_QTEST;
      pred_raddr = PAW'(PAW'(qstart_ff) * PAW'(MAX_NODES) + PAW'(qnode_ff));
      unique case (state_ff)
         asptu_pkg::ST_PCLR: pred_we = 1'b1;
         asptu_pkg::ST_INIT: tot_we = 1'b1;
         asptu_pkg::ST_ECHK: begin
            tot_re    = 1'b1;
            tot_raddr = oth_idx;
         end
         asptu_pkg::ST_ERELAX: begin
            tot_waddr  = NW'(oth_ff);
            tot_wdata  = sum_sat;
            tot_we     = tot_rd > sum_sat;
            pred_we    = tot_rd > sum_sat;
            pred_waddr = PAW'(PAW'(src_ff) * PAW'(MAX_NODES) + PAW'(oth_ff));
            pred_wdata = {1'b1, cur_ff};
         end
         asptu_pkg::ST_SREAD: tot_re = 1'b1;
         default: begin
         end
      endcase
   end

   assign rsp_word.path_node = path_buf_ff[idx_ff];
   assign rsp_word.found     = found_ff;
   assign rsp_word.last      = idx_last;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= asptu_pkg::ST_IDLE;
         node_count_ff <= asptu_pkg::NODE_COUNT_RST;
         edge_count_ff <= '0;
         built_ff      <= 1'b0;
         visited_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) node_count_ff <= csr_wdata;
         if (req_acc && req_word.command == asptu_pkg::CMD_CLEAR) edge_count_ff <= '0;
         if (edge_we) edge_count_ff <= edge_count_ff + ECW'(1);
         if (state_ff == asptu_pkg::ST_PCLR) built_ff <= 1'b1;
         if (state_ff == asptu_pkg::ST_INIT) visited_ff[k_ff] <= (k_ff == src_ff);
         if (state_ff == asptu_pkg::ST_SCMP && k_last && take) visited_ff[k_ff] <= 1'b1;
         else if (state_ff == asptu_pkg::ST_SCMP && k_last && have_ff) begin
            visited_ff[best_ff] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         asptu_pkg::ST_IDLE: begin
            clr_ff    <= '0;
            src_ff    <= '0;
            k_ff      <= '0;
            n_ff      <= (int'(node_count_ff) < MAX_NODES) ? NCW'(node_count_ff)
                                                             : NCW'(MAX_NODES);
            qstart_ff <= req_word.start_node;
            qnode_ff  <= NW'(req_word.end_node);
            cnt_ff    <= '0;
            idx_ff    <= '0;
            len_ff    <= asptu_pkg::COUNT_W'(1);
            found_ff  <= req_word.start_node == req_word.end_node;
            path_buf_ff[0] <= req_word.start_node;
         end
         asptu_pkg::ST_PCLR: clr_ff <= clr_ff + PAW'(1);
         asptu_pkg::ST_INIT: begin
            k_ff <= k_ff + NW'(1);
            if (k_last) begin
               cur_ff       <= src_ff;
               cur_total_ff <= '0;
               step_ff      <= '0;
               e_ff         <= '0;
               seen_ff      <= '0;
            end
         end
         asptu_pkg::ST_ECHK: begin
            oth_ff   <= oth;
            ecost_ff <= ec;
            if (relevant) seen_ff[oth_idx] <= 1'b1;
            // the relax state advances the edge index itself
            if (!(relevant && ec != COST_INF)) e_ff <= e_ff + EAW'(1);
         end
         asptu_pkg::ST_ERELAX: e_ff <= e_ff + EAW'(1);
         asptu_pkg::ST_STEPEND: begin
            k_ff    <= '0;
            have_ff <= 1'b0;
         end
         asptu_pkg::ST_SCMP: begin
            k_ff <= k_ff + NW'(1);
            if (take) begin
               have_ff      <= 1'b1;
               best_ff      <= k_ff;
               best_cost_ff <= tot_rd;
            end
            if (k_last) begin
               cur_ff       <= take ? k_ff : best_ff;
               cur_total_ff <= take ? tot_rd : best_cost_ff;
               step_ff      <= step_ff + NCW'(1);
               e_ff         <= '0;
               seen_ff      <= '0;
            end
         end
         asptu_pkg::ST_SRCEND: begin
            src_ff <= src_ff + NW'(1);
            k_ff   <= '0;
         end
         asptu_pkg::ST_QTEST: begin
            if (q_home) begin
               path_buf_ff[cnt_ff[NDW-1:0]] <= qstart_ff;
               len_ff   <= cnt_ff + asptu_pkg::COUNT_W'(1);
               found_ff <= 1'b1;
            end else if (q_limit) begin
               path_buf_ff[0] <= qstart_ff;
               len_ff   <= asptu_pkg::COUNT_W'(1);
               found_ff <= 1'b0;
            end
         end
         asptu_pkg::ST_QREAD: begin
            if (pred_rd[PDW-1]) begin
               path_buf_ff[cnt_ff[NDW-1:0]] <= NDW'(qnode_ff);
               cnt_ff   <= cnt_ff + asptu_pkg::COUNT_W'(1);
               qnode_ff <= pred_rd[NW-1:0];
            end else begin
               path_buf_ff[0] <= qstart_ff;
               len_ff   <= asptu_pkg::COUNT_W'(1);
               found_ff <= 1'b0;
            end
         end
         asptu_pkg::ST_EMIT: begin
            if (rsp_acc) idx_ff <= idx_ff + NDW'(1);
         end
         default: begin
         end
      endcase
   end

   // edge store
   asptu_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (EAW'(edge_count_ff)),
      .wdata ({req_word.edge_from, req_word.edge_to, COST_BITS'(req_word.edge_cost)}),
      .re    (edge_re),
      .raddr (e_ff),
      .rdata (edge_rd)
   );

   // per-source path totals
   asptu_ram #(.WIDTH(TW), .DEPTH(MAX_NODES), .AW(NW)) u_total_ram (
      .clock (clock),
      .we    (tot_we),
      .waddr (tot_waddr),
      .wdata (tot_wdata),
      .re    (tot_re),
      .raddr (tot_raddr),
      .rdata (tot_rd)
   );

   // predecessor table, {valid, node}
   asptu_ram #(.WIDTH(PDW), .DEPTH(PD), .AW(PAW)) u_pred_ram (
      .clock (clock),
      .we    (pred_we),
      .waddr (pred_waddr),
      .wdata (pred_wdata),
      .re    (pred_re),
      .raddr (pred_raddr),
      .rdata (pred_rd)
   );

   // checks
   `ASPTU_ASSERT_IMPLY(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall, "result while input open")
   `ASPTU_ASSERT_IMPLY(a_fail_single, clock, reset, rsp_valid && !rsp_word.found, rsp_word.last, "failed path not single")
   `ASPTU_ASSERT_NEVER(a_edge_bound, clock, reset, int'(edge_count_ff) > MAX_EDGES, "edge count overflow")
   `ASPTU_ASSERT_IMPLY(a_pred_write, clock, reset, pred_we, state_ff == asptu_pkg::ST_PCLR || state_ff == asptu_pkg::ST_ERELAX, "stray predecessor write")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the all-sources shortest path tree unit.
// Loads edges, builds trees and queries paths; checks each path word against
// a built-in Dijkstra predictor. Depends on asptu_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int NMAX     = 32;
   localparam int EMAX     = 64;
   localparam int TOT_INF  = (1 << 24) - 1;
   localparam int COST_INF = 16'hFFFF;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   asptu_pkg::req_word_type req_word;
   logic                    rsp_valid;
   logic                    rsp_stall;
   asptu_pkg::rsp_word_type rsp_word;
   logic                    csr_we;
   logic [5:0]              csr_wdata;

   all_sources_shortest_path_tree_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [4:0]  edge_a [EMAX];
   logic [4:0]  edge_b [EMAX];
   logic [15:0] edge_w [EMAX];
   int          edge_cnt;
   int          nodes_used;
   logic [4:0]  pred_node [NMAX*NMAX];
   bit          pred_ok   [NMAX*NMAX];
   asptu_pkg::rsp_word_type path_q [$];

   int errors;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_rsp;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
      errors++;
   endtask

   // append one expected word at the tail
   function automatic void expect_word(input asptu_pkg::rsp_word_type r);
      path_q.insert(path_q.size(), r);
   endfunction

   function automatic int edge_cost_between(input int u, input int v);
      for (int e = 0; e < edge_cnt; e++)
         if ((edge_a[e] == u && edge_b[e] == v) || (edge_a[e] == v && edge_b[e] == u))
            return edge_w[e];
      return COST_INF;
   endfunction

   // Dijkstra from every node in use
   task automatic build_trees();
      int  n;
      int  tot [NMAX];
      bit  seen [NMAX];
      int  cur, best, best_c, c, sum;
      bit  have;
      n = nodes_used < NMAX ? nodes_used : NMAX;
      for (int i = 0; i < NMAX*NMAX; i++) pred_ok[i] = 0;
      for (int s = 0; s < n; s++) begin
         for (int k = 0; k < n; k++) begin
            seen[k] = (k == s);
            tot[k]  = (k == s) ? 0 : TOT_INF;
         end
         cur = s;
         for (int step = 0; step < n; step++) begin
            for (int k = 0; k < n; k++) begin
               if (seen[k]) continue;
               c = edge_cost_between(cur, k);
               if (c >= COST_INF) continue;
               sum = c + tot[cur];
               if (sum > TOT_INF) sum = TOT_INF;
               if (tot[k] > sum) begin
                  tot[k] = sum;
                  pred_node[s*NMAX+k] = cur[4:0];
                  pred_ok[s*NMAX+k] = 1;
               end
            end
            if (step + 1 == n) break;
            have = 0; best = 0; best_c = 0;
            for (int k = 0; k < n; k++) begin
               if (seen[k]) continue;
               if (!have || tot[k] < best_c) begin
                  have = 1; best = k; best_c = tot[k];
               end
            end
            if (!have) break;
            seen[best] = 1;
            cur = best;
         end
      end
   endtask

   // expected path words for one query
   task automatic predict_path(input int st, input int en);
      int  hops [NMAX];
      int  nh;
      int  node;
      bit  ok;
      asptu_pkg::rsp_word_type r;
      if (st == en) begin
         r.path_node = st[4:0]; r.found = 1; r.last = 1;
         expect_word(r);
         return;
      end
      ok = 1;
      nh = 0;
      node = en;
      while (node != st) begin
         if (nh >= asptu_pkg::OUT_LIMIT - 1 || nh >= NMAX || !pred_ok[st*NMAX+node]) begin
            ok = 0;
            break;
         end
         hops[nh] = node;
         nh++;
         node = pred_node[st*NMAX+node];
      end
      if (!ok) begin
         r.path_node = st[4:0]; r.found = 0; r.last = 1;
         expect_word(r);
         return;
      end
      hops[nh] = st;
      nh++;
      for (int i = 0; i < nh; i++) begin
         r.path_node = hops[i][4:0];
         r.found = 1;
         r.last = (i == nh - 1);
         expect_word(r);
      end
   endtask

   task automatic predict_word(input asptu_pkg::req_word_type w);
      case (w.command)
         asptu_pkg::CMD_CLEAR: edge_cnt = 0;
         asptu_pkg::CMD_ADD: begin
            if (edge_cnt < EMAX) begin
               edge_a[edge_cnt] = w.edge_from;
               edge_b[edge_cnt] = w.edge_to;
               edge_w[edge_cnt] = w.edge_cost;
               edge_cnt++;
            end
         end
         asptu_pkg::CMD_BUILD: build_trees();
         default: predict_path(w.start_node, w.end_node);
      endcase
   endtask

   // send one word, update the predictor on acceptance; valid stays up
   // until the next send or the next drain
   task automatic send_word(input asptu_pkg::req_word_type w);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(w);
      @(negedge clock);
   endtask

   function automatic asptu_pkg::req_word_type mk(input logic [1:0] cmd, input int a,
                                                  input int b, input int c,
                                                  input int st, input int en);
      asptu_pkg::req_word_type w;
      w.command = cmd; w.edge_from = a[4:0]; w.edge_to = b[4:0];
      w.edge_cost = c[15:0]; w.start_node = st[4:0]; w.end_node = en[4:0];
      return w;
   endfunction

   function automatic asptu_pkg::req_word_type rand_word(input logic [1:0] cmd);
      logic [63:0] raw;
      asptu_pkg::req_word_type w;
      raw = {$urandom, $urandom};
      w = raw[$bits(asptu_pkg::req_word_type)-1:0];
      w.command = cmd;
      return w;
   endfunction

   // drop valid, then wait until the block is idle and all words are back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (path_q.size() != 0 || req_stall) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_node_count(input int n);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= n[5:0];
      @(negedge clock);
      csr_we <= 1'b0;
      nodes_used = n;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (path_q.size() == 0) begin
            report("unexpected word", rsp_word.path_node, 0);
         end else begin
            asptu_pkg::rsp_word_type x;
            x = path_q.pop_front();
            if (rsp_word.path_node !== x.path_node)
               report("path_node", rsp_word.path_node, x.path_node);
            if (rsp_word.found !== x.found) report("found", rsp_word.found, x.found);
            if (rsp_word.last !== x.last) report("last", rsp_word.last, x.last);
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
   end

   task automatic test_directed();
      set_node_count(32);
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 3, 7));       // no build yet
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 5, 5));       // start equals end
      send_word(mk(asptu_pkg::CMD_ADD, 0, 1, 5, 0, 0));
      send_word(mk(asptu_pkg::CMD_ADD, 1, 2, 0, 0, 0));
      send_word(mk(asptu_pkg::CMD_ADD, 2, 31, 65534, 0, 0));
      send_word(mk(asptu_pkg::CMD_ADD, 0, 2, 9, 0, 0));
      send_word(mk(asptu_pkg::CMD_ADD, 3, 4, 65535, 0, 0));     // no-edge marker
      send_word(mk(asptu_pkg::CMD_ADD, 4, 3, 1, 0, 0));         // shadowed by the marker
      send_word(mk(asptu_pkg::CMD_ADD, 5, 6, 3, 0, 0));
      send_word(mk(asptu_pkg::CMD_ADD, 6, 5, 1, 0, 0));
      send_word(mk(asptu_pkg::CMD_BUILD, 0, 0, 0, 0, 0));
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 0, 31));
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 31, 0));
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 3, 4));      // unreachable
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 6, 5));
      send_word(mk(asptu_pkg::CMD_QUERY, 31, 31, 65535, 31, 31));
      // overfill the edge store (the edges added above are still stored)
      for (int i = 0; i < EMAX - 5; i++)
         send_word(mk(asptu_pkg::CMD_ADD, i % 8, (i + 1) % 8, i + 1, 0, 0));
      send_word(mk(asptu_pkg::CMD_BUILD, 0, 0, 0, 0, 0));
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 0, 7));
      send_word(mk(asptu_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
      // node count extremes; endpoint not in use
      set_node_count(1);
      send_word(mk(asptu_pkg::CMD_ADD, 0, 1, 2, 0, 0));
      send_word(mk(asptu_pkg::CMD_BUILD, 0, 0, 0, 0, 0));
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 0, 1));
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 0, 0));
      set_node_count(63);                           // above the node limit
      send_word(mk(asptu_pkg::CMD_BUILD, 0, 0, 0, 0, 0));
      send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 1, 0));
   endtask

   // random graphs: a chain for longer paths plus random edges, then queries
   task automatic test_random_graphs(input int rounds);
      int n;
      for (int r = 0; r < rounds; r++) begin
         n = $urandom_range(2, 12);
         set_node_count(n);
         send_word(mk(asptu_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
         for (int k = 0; k + 1 < n && k < 31; k++)
            if ($urandom_range(3) != 0)
               send_word(mk(asptu_pkg::CMD_ADD, k, k + 1, $urandom_range(1, 40), 0, 0));
         repeat ($urandom_range(2, 5)) begin
            asptu_pkg::req_word_type w;
            w = rand_word(asptu_pkg::CMD_ADD);
            if ($urandom_range(3) != 0) begin
               w.edge_from = 5'($urandom_range(n - 1));
               w.edge_to   = 5'($urandom_range(n - 1));
               if ($urandom_range(4) != 0) w.edge_cost = 16'($urandom_range(60));
            end
            send_word(w);
         end
         send_word(mk(asptu_pkg::CMD_BUILD, 0, 0, 0, 0, 0));
         repeat ($urandom_range(2, 4)) begin
            asptu_pkg::req_word_type w;
            w = rand_word(asptu_pkg::CMD_QUERY);
            if ($urandom_range(4) != 0) begin
               w.start_node = 5'($urandom_range(n - 1));
               w.end_node   = 5'($urandom_range(n - 1));
            end
            send_word(w);
         end
      end
   endtask

   // receiver holds off while the sender keeps offering queries
   task automatic test_backpressure();
      hold_rsp = 1;
      fork
         begin
            repeat (3) send_word(mk(asptu_pkg::CMD_QUERY, 0, 0, 0, 0, 5));
         end
         begin
            for (int c = 0; c < 400; c++) @(negedge clock);
            hold_rsp = 0;
         end
      join
   endtask

   initial begin
      errors = 0;
      hold_rsp = 0;
      send_idle_pct = 17;
      recv_idle_pct = 51;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      edge_cnt = 0;
      nodes_used = 32;
      for (int i = 0; i < NMAX*NMAX; i++) begin
         pred_ok[i] = 0;
         pred_node[i] = '0;
      end
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_graphs(1);
      send_idle_pct = 51;
      recv_idle_pct = 17;
      test_random_graphs(1);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_graphs(1);

      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0 && path_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
